// ----- rtl/collapsing_issue_queue_unit_macros.svh -----
// assertion macros for the collapsing issue queue
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef COLLAPSING_ISSUE_QUEUE_UNIT_MACROS_SVH
`define COLLAPSING_ISSUE_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CIQ_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ciq invariant violated");
`define CIQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ciq sequence violated");
`else
`define CIQ_ASSERT(lbl, expr)
`define CIQ_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- rtl/ciq_pkg.sv -----
// shared types, codes and helpers for the collapsing issue queue
// no dependencies
package ciq_pkg;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned IssueWidth  = 2;
  localparam int unsigned RenameWidth = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_WAKEUP = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_SELECT = 2'd3
  } op_e;

  localparam logic [2:0] TYPE_I = 3'd0;
  localparam logic [2:0] TYPE_S = 3'd1;
  localparam logic [2:0] TYPE_B = 3'd2;
  localparam logic [2:0] TYPE_U = 3'd3;
  localparam logic [2:0] TYPE_J = 3'd4;
  localparam logic [2:0] TYPE_R = 3'd5;

  typedef struct packed {
    logic [15:0] age;
    logic [2:0]  itype;
    logic [1:0]  cls;
    logic [5:0]  tag1;
    logic [5:0]  tag2;
    logic        rdy1;
    logic        rdy2;
    logic [31:0] op1;
    logic [31:0] op2;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic wake;
    logic flush;
    logic kill;
  } cell_ctrl_t;

  function automatic logic entry_ready(entry_t e);
    logic r;
    case (e.itype)
      TYPE_I:                 r = e.rdy1;
      TYPE_S, TYPE_B, TYPE_R: r = e.rdy1 & e.rdy2;
      TYPE_U, TYPE_J:         r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/collapsing_issue_queue_unit.sv -----
// top level of the collapsing issue queue: control sequencer and row of cells
// depends on ciq_pkg, ciq_cell and collapsing_issue_queue_unit_macros.svh
//
// Age-ordered issue queue built as a row of QUEUE_DEPTH cells, oldest in cell 0.
// One request is worked at a time. Insert and wakeup go from acceptance
// straight to the result delivery step. A flush takes one compaction step per
// hole below the youngest survivor: each step shifts every cell at or above the
// lowest hole down by one, so it is bounded by QUEUE_DEPTH. A select scans
// for the oldest ready entry up to ISSUE_WIDTH times, stopping when none is
// ready, then compacts one hole a cycle, then delivers one result per cycle
// while the consumer takes them. Results wait in an output register, so a
// stalled consumer only holds the result delivery step.
`include "collapsing_issue_queue_unit_macros.svh"

module collapsing_issue_queue_unit #(
  parameter int unsigned QUEUE_DEPTH  = ciq_pkg::QueueDepth,
  parameter int unsigned ISSUE_WIDTH  = ciq_pkg::IssueWidth,
  parameter int unsigned RENAME_WIDTH = ciq_pkg::RenameWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // op, age_tag, insn_format, unit_class, src1_tag, src1_ready, src1_value,
  // src2_tag, src2_ready, src2_value, wakeup_tag, wakeup_value, zero pad
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_age_tag, out_type, out_class, out_src1_value, out_src2_value,
  // has_room, occupancy, zero pad
  output logic [95:0]  m_axis_tdata_o,
  // issue_valid
  output logic         m_axis_tuser_o,
  // last
  output logic         m_axis_tlast_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW = (ISSUE_WIDTH > 1) ? $clog2(ISSUE_WIDTH) : 1;
  localparam int unsigned NW = $clog2(ISSUE_WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_EMIT
  } state_e;

  // issued instruction kept until results go out
  typedef struct packed {
    logic [15:0] age;
    logic [2:0]  itype;
    logic [1:0]  cls;
    logic [31:0] op1;
    logic [31:0] op2;
  } iss_t;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [NW-1:0]   n_iss_q;
  logic [BW-1:0]   scan_cnt_q;
  logic [BW-1:0]   emit_idx_q;
  logic            m_valid_q;
  logic [95:0]     m_data_q;
  logic            m_user_q;
  logic            m_last_q;
  iss_t            buf_q [ISSUE_WIDTH];

  // request fields
  logic            accept;
  ciq_pkg::op_e    in_op;
  logic [15:0]     in_age;
  ciq_pkg::entry_t new_entry;
  logic [5:0]      wake_tag;
  logic [31:0]     wake_val;

  assign in_op           = ciq_pkg::op_e'(s_axis_tdata_i[1:0]);
  assign in_age          = s_axis_tdata_i[17:2];
  assign new_entry.age   = s_axis_tdata_i[17:2];
  assign new_entry.itype = s_axis_tdata_i[20:18];
  assign new_entry.cls   = s_axis_tdata_i[22:21];
  assign new_entry.tag1  = s_axis_tdata_i[28:23];
  assign new_entry.rdy1  = s_axis_tdata_i[29];
  assign new_entry.op1   = s_axis_tdata_i[61:30];
  assign new_entry.tag2  = s_axis_tdata_i[67:62];
  assign new_entry.rdy2  = s_axis_tdata_i[68];
  assign new_entry.op2   = s_axis_tdata_i[100:69];
  assign wake_tag        = s_axis_tdata_i[106:101];
  assign wake_val        = s_axis_tdata_i[138:107];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // the row of cells
  ciq_pkg::entry_t    ent   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld;
  ciq_pkg::cell_ctrl_t ctrl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hole_below;
  logic               compact_done;
  logic [CW-1:0]      lead;
  logic               any_rdy;
  logic [QW-1:0]      sel_idx;
  logic               not_full;

  assign not_full = (count_q < CW'(QUEUE_DEPTH));

  // hole tracking and oldest ready search
  always_comb begin
    hole_below   = '0;
    compact_done = 1'b1;
    lead         = CW'(QUEUE_DEPTH);
    any_rdy      = 1'b0;
    sel_idx      = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hole_below[i] = !vld[i] || ((i > 0) ? hole_below[(i > 0) ? i - 1 : 0] : 1'b0);
      if (hole_below[i] && vld[i]) compact_done = 1'b0;
    end
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!vld[i]) lead = CW'(i);
      if (vld[i] && ciq_pkg::entry_ready(ent[i])) begin
        any_rdy = 1'b1;
        sel_idx = QW'(i);
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    ciq_pkg::entry_t nb;
    logic            nb_valid;
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign nb       = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb       = ent[g + 1];
      assign nb_valid = vld[g + 1];
    end

    // shift only cells at or above the lowest hole
    assign ctrl[g].shift = (state_q == ST_COMPACT) && !compact_done && hole_below[g];
    assign ctrl[g].load  = accept && (in_op == ciq_pkg::OP_INSERT) && not_full &&
                           (count_q == CW'(g));
    assign ctrl[g].wake  = accept && (in_op == ciq_pkg::OP_WAKEUP);
    assign ctrl[g].flush = accept && (in_op == ciq_pkg::OP_FLUSH);
    assign ctrl[g].kill  = (state_q == ST_SCAN) && any_rdy && (sel_idx == QW'(g));

    ciq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .new_i      (new_entry),
      .nb_i       (nb),
      .nb_valid_i (nb_valid),
      .wake_tag_i (wake_tag),
      .wake_val_i (wake_val),
      .redirect_i (in_age),
      .entry_o    (ent[g]),
      .valid_o    (vld[g])
    );
  end

  // status fields shared by every result
  logic       has_room;
  logic [4:0] occ;
  assign has_room = (32'(count_q) + 32'(RENAME_WIDTH)) <= 32'(QUEUE_DEPTH);
  assign occ      = 5'(count_q);

  // issued instruction capture
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && any_rdy) begin
      buf_q[n_iss_q[BW-1:0]] <= '{age:   ent[sel_idx].age,
                                  itype: ent[sel_idx].itype,
                                  cls:   ent[sel_idx].cls,
                                  op1:   ent[sel_idx].op1,
                                  op2:   ent[sel_idx].op2};
    end
  end

  iss_t cur;
  assign cur = buf_q[emit_idx_q];

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      n_iss_q    <= '0;
      scan_cnt_q <= '0;
      emit_idx_q <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      // outside the delivery step a taken result just leaves the register
      if (m_axis_tready_i && (state_q != ST_EMIT)) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            n_iss_q    <= '0;
            scan_cnt_q <= '0;
            emit_idx_q <= '0;
            case (in_op)
              ciq_pkg::OP_INSERT: begin
                if (not_full) count_q <= count_q + CW'(1);
                state_q <= ST_EMIT;
              end
              ciq_pkg::OP_WAKEUP: state_q <= ST_EMIT;
              ciq_pkg::OP_FLUSH:  state_q <= ST_COMPACT;
              ciq_pkg::OP_SELECT: state_q <= ST_SCAN;
              default:            state_q <= ST_EMIT;
            endcase
          end
        end
        ST_SCAN: begin
          if (any_rdy) n_iss_q <= n_iss_q + NW'(1);
          if (!any_rdy || (scan_cnt_q == BW'(ISSUE_WIDTH - 1))) begin
            state_q <= ST_COMPACT;
          end else begin
            scan_cnt_q <= scan_cnt_q + BW'(1);
          end
        end
        ST_COMPACT: begin
          if (compact_done) begin
            count_q <= lead;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            if (n_iss_q == '0) begin
              // no instruction issued: one status-only result
              m_data_q <= {5'd0, occ, has_room, 85'd0};
              m_user_q <= 1'b0;
              m_last_q <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              m_data_q <= {5'd0, occ, has_room, cur.op2, cur.op1, cur.cls,
                           cur.itype, cur.age};
              m_user_q <= 1'b1;
              if ((NW'(emit_idx_q) + NW'(1)) == n_iss_q) begin
                m_last_q <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                m_last_q   <= 1'b0;
                emit_idx_q <= emit_idx_q + BW'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // occupancy never exceeds the row
  `CIQ_ASSERT(a_count_range, count_q <= CW'(QUEUE_DEPTH))
  // issued count never exceeds the issue width
  `CIQ_ASSERT(a_iss_range, 32'(n_iss_q) <= ISSUE_WIDTH)
  // every accepted request leaves idle
  `CIQ_ASSERT_IMPL(a_busy_after_accept, accept, state_q != ST_IDLE)

endmodule

// ----- rtl/ciq_cell.sv -----
// one queue slot: holds an entry, takes its upper neighbor on a shift
// depends on ciq_pkg
module ciq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ciq_pkg::cell_ctrl_t ctrl_i,
  input  ciq_pkg::entry_t   new_i,
  input  ciq_pkg::entry_t   nb_i,
  input  logic              nb_valid_i,
  input  logic [5:0]        wake_tag_i,
  input  logic [31:0]       wake_val_i,
  input  logic [15:0]       redirect_i,
  output ciq_pkg::entry_t   entry_o,
  output logic              valid_o
);

  ciq_pkg::entry_t e_q, e_d;
  logic v_q, v_d;

  always_comb begin
    e_d = e_q;
    v_d = v_q;
    if (ctrl_i.shift) begin
      e_d = nb_i;
      v_d = nb_valid_i;
    end else if (ctrl_i.load) begin
      e_d = new_i;
      v_d = 1'b1;
    end else if (ctrl_i.wake) begin
      if (e_q.tag1 == wake_tag_i) begin
        e_d.rdy1 = 1'b1;
        e_d.op1  = wake_val_i;
      end
      if (e_q.tag2 == wake_tag_i) begin
        e_d.rdy2 = 1'b1;
        e_d.op2  = wake_val_i;
      end
    end
    if (ctrl_i.flush && v_q && (e_q.age > redirect_i)) begin
      v_d = 1'b0;
    end
    if (ctrl_i.kill) begin
      v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d;
  end

  assign entry_o = e_q;
  assign valid_o = v_q;

endmodule
